### hw/rtl/ppwg_pkg.sv
// Shared types and constants for the ping-pong wavetable tone generator.
// Used by every module of the block; depends on nothing.
package ppwg_pkg;

	localparam int TableEntries      = 16;
	localparam int SubstepsPerSample = 256;

	localparam int FREQ_W   = 12;
	localparam int ENTRY_W  = 8;
	localparam int SUM_W    = 16;
	localparam int OFFSET_W = 3;
	localparam int DATA_W   = 8;

	// Frequency code that silences the voice (also the reset value).
	localparam logic [FREQ_W-1:0] FREQ_MUTE = 12'hfff;

	typedef enum logic [0:0] {
		REQ_WRITE = 1'b0,
		REQ_TICK  = 1'b1
	} req_type_t;

	// Register offsets.
	localparam logic [OFFSET_W-1:0] OFFS_FREQ_HI    = 3'd0;
	localparam logic [OFFSET_W-1:0] OFFS_FREQ_LO    = 3'd1;
	localparam logic [OFFSET_W-1:0] OFFS_WAVE_FIRST = 3'd2;
	localparam logic [OFFSET_W-1:0] OFFS_WAVE_LAST  = 3'd5;

	typedef struct packed {
		logic                en;
		logic [OFFSET_W-1:0] offset;
		logic [DATA_W-1:0]   data;
	} wr_req_t;

	typedef struct packed {
		logic                    done;
		logic                    muted;
		logic signed [SUM_W-1:0] sum;
	} eng_res_t;

endpackage

### hw/rtl/ping_pong_wavetable_generator_core.sv
// Top level of the single-voice ping-pong wavetable tone generator.
// Depends on ppwg_pkg, ppwg_regs and ppwg_engine.
//
// The block takes one item at a time on the input channel. A register write
// (req_type 0) gives no result: offsets 0 and 1 load
// the high and low six bits of the 12-bit frequency, offsets 2 to 5 load a pair
// of forward table entries and their complemented mirror entries, offsets 6
// and 7 are dropped. A sample tick (req_type 1) gives exactly one result item:
// the signed sum of the current table entry over 256 sub-steps, with the phase
// counter climbing to 0x1000, reloading from the frequency and advancing the
// table position each time. A tick runs one sub-step per clock through a single
// accumulator adder; after the last sub-step the sequencer hands the sum to the
// output register and returns to idle, and only then is the next item taken.
// With the frequency at 0xfff the voice is muted: the tick skips the sub-steps,
// returns zero with muted set and leaves counter and position alone. The result
// sits in an output register, so a stalled result does not hold up a following
// write; a tick finishing while the previous result is still stalled waits
// until that result is taken.
module ping_pong_wavetable_generator_core #(
	parameter int TABLE_ENTRIES       = ppwg_pkg::TableEntries,
	parameter int SUBSTEPS_PER_SAMPLE = ppwg_pkg::SubstepsPerSample
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   req_type,
	input  logic [ppwg_pkg::OFFSET_W-1:0]          reg_offset,
	input  logic [ppwg_pkg::DATA_W-1:0]            reg_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [ppwg_pkg::SUM_W-1:0]      sample_sum,
	output logic                                   muted
);

	localparam int POS_W = $clog2(TABLE_ENTRIES);

	ppwg_pkg::wr_req_t                    wr;
	ppwg_pkg::eng_res_t                   res;
	logic [POS_W-1:0]                     pos;
	logic [ppwg_pkg::FREQ_W-1:0]          freq;
	logic signed [ppwg_pkg::ENTRY_W-1:0]  entry;
	logic                                 busy;
	logic                                 in_take;
	logic                                 out_free;
	logic                                 out_valid_q;
	logic signed [ppwg_pkg::SUM_W-1:0]    sample_sum_q;
	logic                                 muted_q;

	// Take an item only while the sequencer is idle.
	assign in_stall = busy;
	assign in_take  = in_valid && !busy;

	assign wr.en     = in_take && (req_type == ppwg_pkg::REQ_WRITE);
	assign wr.offset = reg_offset;
	assign wr.data   = reg_data;

	// Output slot is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || !out_stall;

	ppwg_regs #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.POS_W        (POS_W)
	) u_regs (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.pos   (pos),
		.freq  (freq),
		.entry (entry)
	);

	ppwg_engine #(
		.TABLE_ENTRIES      (TABLE_ENTRIES),
		.SUBSTEPS_PER_SAMPLE(SUBSTEPS_PER_SAMPLE),
		.POS_W              (POS_W)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_take && (req_type == ppwg_pkg::REQ_TICK)),
		.out_free(out_free),
		.freq    (freq),
		.entry   (entry),
		.pos     (pos),
		.busy    (busy),
		.res     (res)
	);

	// Output register: load a finished sum, hold while stalled, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			sample_sum_q <= res.sum;
			muted_q      <= res.muted;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_sum = sample_sum_q;
	assign muted      = muted_q;

endmodule

### hw/rtl/ppwg_regs.sv
// Frequency register and mirrored wave table of the tone generator.
// Depends on ppwg_pkg.
module ppwg_regs #(
	parameter int TABLE_ENTRIES = ppwg_pkg::TableEntries,
	parameter int POS_W         = $clog2(TABLE_ENTRIES)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ppwg_pkg::wr_req_t                    wr,
	input  logic [POS_W-1:0]                     pos,
	output logic [ppwg_pkg::FREQ_W-1:0]          freq,
	output logic signed [ppwg_pkg::ENTRY_W-1:0]  entry
);

	logic [ppwg_pkg::FREQ_W-1:0]  freq_q;
	logic [ppwg_pkg::ENTRY_W-1:0] table_q [TABLE_ENTRIES];

	logic                          wave_wr;
	logic [1:0]                    pair_full;
	logic [POS_W-1:0]              idx_lo;
	logic [POS_W-1:0]              idx_lo1;
	logic [POS_W-1:0]              idx_mir1;
	logic [POS_W-1:0]              idx_mir0;
	logic [ppwg_pkg::ENTRY_W-1:0]  first_val;
	logic [ppwg_pkg::ENTRY_W-1:0]  second_val;

	always_comb begin
		wave_wr    = wr.en && (wr.offset >= ppwg_pkg::OFFS_WAVE_FIRST)
			&& (wr.offset <= ppwg_pkg::OFFS_WAVE_LAST);
		pair_full  = 2'(wr.offset - ppwg_pkg::OFFS_WAVE_FIRST);
		idx_lo     = POS_W'({pair_full, 1'b0});
		idx_lo1    = idx_lo + POS_W'(1);
		idx_mir1   = POS_W'(TABLE_ENTRIES - 2) - idx_lo;
		idx_mir0   = POS_W'(TABLE_ENTRIES - 1) - idx_lo;
		first_val  = {1'b0, wr.data[6:4], 4'b0000};
		second_val = {1'b0, wr.data[2:0], 4'b0000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= ppwg_pkg::FREQ_MUTE;
		end else if (wr.en && wr.offset == ppwg_pkg::OFFS_FREQ_HI) begin
			freq_q[11:6] <= wr.data[7:2];
		end else if (wr.en && wr.offset == ppwg_pkg::OFFS_FREQ_LO) begin
			freq_q[5:0] <= wr.data[5:0];
		end
	end

	// Load a forward pair and its complemented mirror pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				table_q[i] <= '0;
			end
		end else if (wave_wr) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (POS_W'(i) == idx_lo) begin
					table_q[i] <= first_val;
				end else if (POS_W'(i) == idx_lo1) begin
					table_q[i] <= second_val;
				end else if (POS_W'(i) == idx_mir1) begin
					table_q[i] <= ~second_val;
				end else if (POS_W'(i) == idx_mir0) begin
					table_q[i] <= ~first_val;
				end
			end
		end
	end

	assign freq  = freq_q;
	assign entry = $signed(table_q[pos]);

endmodule

### hw/rtl/ppwg_engine.sv
// Sub-step sequencer: one shared accumulator adder, phase counter and position.
// Depends on ppwg_pkg.
module ppwg_engine #(
	parameter int TABLE_ENTRIES       = ppwg_pkg::TableEntries,
	parameter int SUBSTEPS_PER_SAMPLE = ppwg_pkg::SubstepsPerSample,
	parameter int POS_W               = $clog2(TABLE_ENTRIES)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                out_free,
	input  logic [ppwg_pkg::FREQ_W-1:0]         freq,
	input  logic signed [ppwg_pkg::ENTRY_W-1:0] entry,
	output logic [POS_W-1:0]                    pos,
	output logic                                busy,
	output ppwg_pkg::eng_res_t                  res
);

	localparam int STEP_W = $clog2(SUBSTEPS_PER_SAMPLE);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUBSTEPS_PER_SAMPLE - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_PUSH = 3'b100
	} state_t;

	state_t                          state_q;
	logic [STEP_W-1:0]               step_q;
	logic [ppwg_pkg::FREQ_W-1:0]     phase_q;
	logic [POS_W-1:0]                pos_q;
	logic signed [ppwg_pkg::SUM_W-1:0] sum_q;
	logic                            muted_q;
	logic signed [ppwg_pkg::SUM_W-1:0] sum_next;

	assign sum_next = sum_q + ppwg_pkg::SUM_W'(entry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			phase_q <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
			muted_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						sum_q   <= '0;
						step_q  <= '0;
						muted_q <= (freq == ppwg_pkg::FREQ_MUTE);
						state_q <= (freq == ppwg_pkg::FREQ_MUTE) ? ST_PUSH : ST_RUN;
					end
				end
				ST_RUN: begin
					sum_q  <= sum_next;
					step_q <= step_q + STEP_W'(1);
					// Reload from the frequency when the counter would reach 0x1000.
					if (phase_q == '1) begin
						phase_q <= freq;
						pos_q   <= pos_q + POS_W'(1);
					end else begin
						phase_q <= phase_q + ppwg_pkg::FREQ_W'(1);
					end
					if (step_q == LAST_STEP) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign pos       = pos_q;
	assign busy      = (state_q != ST_IDLE);
	assign res.done  = (state_q == ST_PUSH) && out_free;
	assign res.muted = muted_q;
	assign res.sum   = sum_q;

endmodule

### hw/rtl/ppwg_checker.sv
// Port-level checks for the tone generator, bound to the top level.
// Depends on ping_pong_wavetable_generator_core and ppwg_pkg.
module ppwg_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 req_type,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic signed [ppwg_pkg::SUM_W-1:0]    sample_sum,
	input logic                                 muted
);

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_sum) && $stable(muted))
		else $error("stalled result item changed");

	// A muted tick reports silence.
	a_muted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && muted |-> sample_sum == '0)
		else $error("muted result with nonzero sum");

	// An accepted tick keeps the input side busy in the next cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type == ppwg_pkg::REQ_TICK |=> in_stall)
		else $error("tick accepted but block not busy");

	// A register write never raises a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type == ppwg_pkg::REQ_WRITE |=> !$rose(out_valid))
		else $error("register write produced a result item");

endmodule

bind ping_pong_wavetable_generator_core ppwg_checker u_ppwg_checker (.*);
